// File: src/nra_pkg.sv
`default_nettype none

package nra_pkg;

    localparam int MaxGpus = 16;
    localparam int SlotW = 16;
    localparam int CpuW = 10;
    localparam int MemW = 24;
    localparam int GpuW = 5;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 24;
    localparam int InDataW = 56;
    localparam int OutDataW = 64;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam logic [CfgIdxW-1:0] REG_NODE_ONLINE = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_TOTAL_CPUS = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_TOTAL_MEMORY = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_TOTAL_GPUS = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_RESERVED_CPUS = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_RESERVED_MEMORY = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_RESERVED_GPUS = 3'd6;

    typedef enum logic [3:0] {
        ST_OK = 4'd0,
        ST_OFFLINE = 4'd1,
        ST_INVALID = 4'd2,
        ST_NO_FIT = 4'd3,
        ST_SLOTS_SHORT = 4'd4,
        ST_COUNT_MISMATCH = 4'd5,
        ST_EXCEEDS_ALLOCATED = 4'd6,
        ST_BAD_SLOT = 4'd7,
        ST_BAD_CONFIG = 4'd8
    } status_t;

    typedef struct packed {
        logic            node_online;
        logic [CpuW-1:0] total_cpus;
        logic [MemW-1:0] total_memory;
        logic [GpuW-1:0] total_gpus;
        logic [CpuW-1:0] reserved_cpus;
        logic [MemW-1:0] reserved_memory;
        logic [GpuW-1:0] reserved_gpus;
    } cfg_t;

    typedef struct packed {
        logic             kind;
        logic [CpuW-1:0]  req_cpus;
        logic [MemW-1:0]  req_memory;
        logic [GpuW-1:0]  req_gpus;
        logic [SlotW-1:0] release_mask;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic [SlotW-1:0] granted_mask;
        logic [CpuW-1:0]  avail_cpus;
        logic [MemW-1:0]  avail_memory;
        logic [GpuW-1:0]  avail_gpus;
    } res_t;

    typedef struct packed {
        logic [CpuW-1:0]  used_cpus;
        logic [MemW-1:0]  used_memory;
        logic [GpuW-1:0]  used_gpus;
        logic [SlotW-1:0] slot_busy;
    } acct_t;

    function automatic logic [GpuW-1:0] popcount16(input logic [SlotW-1:0] v);
        logic [GpuW-1:0] n;
        n = '0;
        for (int i = 0; i < SlotW; i++) begin
            n = n + GpuW'(v[i]);
        end
        return n;
    endfunction

    // Total minus reserved minus used, held at zero when either step would go negative.
    function automatic logic [MemW-1:0] floor_sub(input logic [MemW-1:0] a,
                                                  input logic [MemW-1:0] b,
                                                  input logic [MemW-1:0] c);
        logic [MemW-1:0] d;
        d = a - b;
        if (a < b || d < c) begin
            return '0;
        end
        return d - c;
    endfunction

endpackage

`default_nettype wire

// File: src/node_resource_allocator.sv
`default_nettype none

// Channel     Direction  Carries
// s_axis      in         one allocate or release request
// m_axis      out        one result per request
// cfg         in         register index and write data
//
// A request is registered, evaluated combinationally and its result registered with the
// updated accounting, so one request per cycle is accepted while m_tready stays high.
// m_tvalid is set once the request has passed the input register and then the result register.
// A stalled result holds the request behind it in the input register.
// Reset clears the valid flags, the accounting and the configuration; data registers are not reset.

module node_resource_allocator (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // req_cpus, req_memory, req_gpus, release_mask; zero fill to 56 bits
    input  wire logic [nra_pkg::InDataW-1:0]     s_tdata,
    // kind
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // status, granted_mask, avail_cpus, avail_memory, avail_gpus; zero fill to 64 bits
    output logic [nra_pkg::OutDataW-1:0]         m_tdata,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [nra_pkg::CfgIdxW-1:0]     cfg_index,
    input  wire logic [nra_pkg::CfgDataW-1:0]    cfg_data
);

    nra_pkg::cfg_t  cfg;
    logic           cfg_bad;
    nra_pkg::req_t  req_reg;
    nra_pkg::req_t  req_next;
    logic           in_valid_reg;
    nra_pkg::res_t  res_reg;
    nra_pkg::res_t  res_eval;
    logic           out_valid_reg;
    nra_pkg::acct_t acct_reg;
    nra_pkg::acct_t acct_eval;
    logic           advance;

    assign cfg_ready = 1'b1;

    nra_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg),
        .cfg_bad  (cfg_bad)
    );

    nra_eval u_eval (
        .cfg       (cfg),
        .cfg_bad   (cfg_bad),
        .acct      (acct_reg),
        .req       (req_reg),
        .acct_next (acct_eval),
        .res       (res_eval)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        req_next.kind = s_tuser;
        req_next.req_cpus = s_tdata[9:0];
        req_next.req_memory = s_tdata[33:10];
        req_next.req_gpus = s_tdata[38:34];
        req_next.release_mask = s_tdata[54:39];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            acct_reg <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                acct_reg <= acct_eval;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            req_reg <= req_next;
        end
        if (advance) begin
            res_reg <= res_eval;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {5'd0, res_reg.avail_gpus, res_reg.avail_memory, res_reg.avail_cpus,
                      res_reg.granted_mask, res_reg.status};

endmodule

`default_nettype wire

// File: src/nra_cfg.sv
`default_nettype none

module nra_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           wr_en,
    input  wire logic [nra_pkg::CfgIdxW-1:0]    wr_index,
    input  wire logic [nra_pkg::CfgDataW-1:0]   wr_data,
    output nra_pkg::cfg_t                       cfg,
    output logic                                cfg_bad
);

    nra_pkg::cfg_t cfg_reg;
    nra_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                nra_pkg::REG_NODE_ONLINE: begin
                    cfg_next.node_online = wr_data[0];
                end
                nra_pkg::REG_TOTAL_CPUS: begin
                    cfg_next.total_cpus = wr_data[nra_pkg::CpuW-1:0];
                end
                nra_pkg::REG_TOTAL_MEMORY: begin
                    cfg_next.total_memory = wr_data[nra_pkg::MemW-1:0];
                end
                nra_pkg::REG_TOTAL_GPUS: begin
                    cfg_next.total_gpus = wr_data[nra_pkg::GpuW-1:0];
                end
                nra_pkg::REG_RESERVED_CPUS: begin
                    cfg_next.reserved_cpus = wr_data[nra_pkg::CpuW-1:0];
                end
                nra_pkg::REG_RESERVED_MEMORY: begin
                    cfg_next.reserved_memory = wr_data[nra_pkg::MemW-1:0];
                end
                nra_pkg::REG_RESERVED_GPUS: begin
                    cfg_next.reserved_gpus = wr_data[nra_pkg::GpuW-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;
    assign cfg_bad = (cfg_reg.reserved_cpus > cfg_reg.total_cpus)
                  || (cfg_reg.reserved_memory > cfg_reg.total_memory)
                  || (cfg_reg.reserved_gpus > cfg_reg.total_gpus)
                  || (cfg_reg.total_gpus > nra_pkg::GpuW'(nra_pkg::MaxGpus));

endmodule

`default_nettype wire

// File: src/nra_eval.sv
`default_nettype none

module nra_eval (
    input  wire nra_pkg::cfg_t   cfg,
    input  wire logic            cfg_bad,
    input  wire nra_pkg::acct_t  acct,
    input  wire nra_pkg::req_t   req,
    output nra_pkg::acct_t       acct_next,
    output nra_pkg::res_t        res
);

    logic [nra_pkg::SlotW-1:0] range_mask;
    logic [nra_pkg::SlotW-1:0] free_mask;
    logic [nra_pkg::SlotW-1:0] pick_mask;
    logic [nra_pkg::GpuW-1:0]  free_cnt;
    logic [nra_pkg::GpuW-1:0]  rel_cnt;
    logic [nra_pkg::CpuW-1:0]  avail_cpus_pre;
    logic [nra_pkg::MemW-1:0]  avail_mem_pre;
    logic [nra_pkg::GpuW-1:0]  avail_gpus_pre;

    always_comb begin
        for (int i = 0; i < nra_pkg::SlotW; i++) begin
            range_mask[i] = (nra_pkg::GpuW'(i) < cfg.total_gpus)
                         && (nra_pkg::GpuW'(i) >= cfg.reserved_gpus);
        end
    end

    assign free_mask = range_mask & ~acct.slot_busy;
    assign free_cnt = nra_pkg::popcount16(free_mask);
    assign rel_cnt = nra_pkg::popcount16(req.release_mask);

    // A free slot is taken when fewer than the requested count of free slots lie below it.
    always_comb begin
        for (int i = 0; i < nra_pkg::SlotW; i++) begin
            pick_mask[i] = free_mask[i]
                && (nra_pkg::popcount16(free_mask & ((16'd1 << i) - 16'd1)) < req.req_gpus);
        end
    end

    assign avail_cpus_pre = nra_pkg::CpuW'(nra_pkg::floor_sub(
        nra_pkg::MemW'(cfg.total_cpus), nra_pkg::MemW'(cfg.reserved_cpus),
        nra_pkg::MemW'(acct.used_cpus)));
    assign avail_mem_pre = nra_pkg::floor_sub(cfg.total_memory, cfg.reserved_memory,
                                              acct.used_memory);
    assign avail_gpus_pre = nra_pkg::GpuW'(nra_pkg::floor_sub(
        nra_pkg::MemW'(cfg.total_gpus), nra_pkg::MemW'(cfg.reserved_gpus),
        nra_pkg::MemW'(acct.used_gpus)));

    always_comb begin
        acct_next = acct;
        res.status = nra_pkg::ST_OK;
        res.granted_mask = '0;
        if (cfg_bad) begin
            res.status = nra_pkg::ST_BAD_CONFIG;
        end else if (req.kind == nra_pkg::KIND_ALLOC) begin
            if (!cfg.node_online) begin
                res.status = nra_pkg::ST_OFFLINE;
            end else if (req.req_cpus == '0 && req.req_memory == '0 && req.req_gpus == '0) begin
                res.status = nra_pkg::ST_INVALID;
            end else if (req.req_cpus > avail_cpus_pre || req.req_memory > avail_mem_pre
                         || req.req_gpus > avail_gpus_pre) begin
                res.status = nra_pkg::ST_NO_FIT;
            end else if (free_cnt < req.req_gpus) begin
                res.status = nra_pkg::ST_SLOTS_SHORT;
            end else begin
                acct_next.used_cpus = acct.used_cpus + req.req_cpus;
                acct_next.used_memory = acct.used_memory + req.req_memory;
                acct_next.used_gpus = acct.used_gpus + req.req_gpus;
                acct_next.slot_busy = acct.slot_busy | pick_mask;
                res.granted_mask = pick_mask;
            end
        end else begin
            if (rel_cnt != req.req_gpus) begin
                res.status = nra_pkg::ST_COUNT_MISMATCH;
            end else if (req.req_cpus > acct.used_cpus || req.req_memory > acct.used_memory
                         || req.req_gpus > acct.used_gpus) begin
                res.status = nra_pkg::ST_EXCEEDS_ALLOCATED;
            end else if ((req.release_mask & ~(range_mask & acct.slot_busy)) != '0) begin
                res.status = nra_pkg::ST_BAD_SLOT;
            end else begin
                acct_next.used_cpus = acct.used_cpus - req.req_cpus;
                acct_next.used_memory = acct.used_memory - req.req_memory;
                acct_next.used_gpus = acct.used_gpus - req.req_gpus;
                acct_next.slot_busy = acct.slot_busy & ~req.release_mask;
            end
        end
        res.avail_cpus = nra_pkg::CpuW'(nra_pkg::floor_sub(
            nra_pkg::MemW'(cfg.total_cpus), nra_pkg::MemW'(cfg.reserved_cpus),
            nra_pkg::MemW'(acct_next.used_cpus)));
        res.avail_memory = nra_pkg::floor_sub(cfg.total_memory, cfg.reserved_memory,
                                              acct_next.used_memory);
        res.avail_gpus = nra_pkg::GpuW'(nra_pkg::floor_sub(
            nra_pkg::MemW'(cfg.total_gpus), nra_pkg::MemW'(cfg.reserved_gpus),
            nra_pkg::MemW'(acct_next.used_gpus)));
    end

endmodule

`default_nettype wire
